// File: hdl/bus_voltage_fault_monitor_assert.svh
// ----------------------------------------------------------------------------
// Bus voltage fault monitor assertion macros
// Property wrappers shared by the checker, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUS_VOLTAGE_FAULT_MONITOR_ASSERT_SVH
`define BUS_VOLTAGE_FAULT_MONITOR_ASSERT_SVH

// Same-cycle implication
`define BVFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bus voltage fault monitor: check failed");

// Next-cycle implication
`define BVFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bus voltage fault monitor: check failed");

`endif

// File: hdl/bvfm_pkg.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor package
// Shared types, register indexes, fault codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvfm_pkg;

    localparam int REG_W     = 16;
    localparam int VOLT_W    = 16;
    localparam int ACC_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CODE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLTS_PER_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_OV_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_LEVEL         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UV_LEVEL         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_CONFIRM     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_CONFIRM       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UV_CONFIRM       = 3'd7;

    localparam logic [REG_W-1:0] RST_VOLTS_PER_COUNT = 16'd256;
    localparam logic [REG_W-1:0] RST_FILTER_ALPHA    = 16'd3277;
    localparam logic [REG_W-1:0] RST_HARD_OV_LEVEL   = 16'd15360;
    localparam logic [REG_W-1:0] RST_OV_LEVEL        = 16'd14336;
    localparam logic [REG_W-1:0] RST_UV_LEVEL        = 16'd2048;
    localparam logic [REG_W-1:0] RST_HARD_CONFIRM    = 16'd2;
    localparam logic [REG_W-1:0] RST_OV_CONFIRM      = 16'd200;
    localparam logic [REG_W-1:0] RST_UV_CONFIRM      = 16'd2000;

    localparam logic [CODE_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] FAULT_OVER  = 2'd1;
    localparam logic [CODE_W-1:0] FAULT_UNDER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FILTER,
        ST_ACCUM,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [REG_W-1:0] volts_per_count;
        logic [REG_W-1:0] filter_alpha;
        logic [REG_W-1:0] hard_ov_level;
        logic [REG_W-1:0] ov_level;
        logic [REG_W-1:0] uv_level;
        logic [REG_W-1:0] hard_confirm;
        logic [REG_W-1:0] ov_confirm;
        logic [REG_W-1:0] uv_confirm;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic scale;
        logic filter;
        logic accum;
        logic decide;
    } cmd_t;

endpackage

// File: hdl/bvfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor configuration registers
// Eight 16-bit write-only registers loaded from the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvfm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_enable,
    input  logic [bvfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bvfm_pkg::REG_W-1:0]     cfg_data,
    output bvfm_pkg::cfg_t                 cfg
);

    bvfm_pkg::cfg_t cfg_reg;
    bvfm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                bvfm_pkg::CFG_VOLTS_PER_COUNT: cfg_next.volts_per_count = cfg_data;
                bvfm_pkg::CFG_FILTER_ALPHA:    cfg_next.filter_alpha    = cfg_data;
                bvfm_pkg::CFG_HARD_OV_LEVEL:   cfg_next.hard_ov_level   = cfg_data;
                bvfm_pkg::CFG_OV_LEVEL:        cfg_next.ov_level        = cfg_data;
                bvfm_pkg::CFG_UV_LEVEL:        cfg_next.uv_level        = cfg_data;
                bvfm_pkg::CFG_HARD_CONFIRM:    cfg_next.hard_confirm    = cfg_data;
                bvfm_pkg::CFG_OV_CONFIRM:      cfg_next.ov_confirm      = cfg_data;
                bvfm_pkg::CFG_UV_CONFIRM:      cfg_next.uv_confirm      = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volts_per_count <= bvfm_pkg::RST_VOLTS_PER_COUNT;
            cfg_reg.filter_alpha    <= bvfm_pkg::RST_FILTER_ALPHA;
            cfg_reg.hard_ov_level   <= bvfm_pkg::RST_HARD_OV_LEVEL;
            cfg_reg.ov_level        <= bvfm_pkg::RST_OV_LEVEL;
            cfg_reg.uv_level        <= bvfm_pkg::RST_UV_LEVEL;
            cfg_reg.hard_confirm    <= bvfm_pkg::RST_HARD_CONFIRM;
            cfg_reg.ov_confirm      <= bvfm_pkg::RST_OV_CONFIRM;
            cfg_reg.uv_confirm      <= bvfm_pkg::RST_UV_CONFIRM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/bvfm_ctrl.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor controller
// Sequences scale, filter, accumulate and decide steps; owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvfm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           sample_valid,
    output logic           sample_stall,
    output logic           result_valid,
    input  logic           result_stall,
    output bvfm_pkg::cmd_t cmd
);

    bvfm_pkg::state_t state_reg;
    bvfm_pkg::state_t state_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             out_free;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next   = state_reg;
        sample_stall = 1'b1;
        cmd          = '0;
        case (state_reg)
            bvfm_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                cmd.load     = sample_valid;
                if (sample_valid)
                    state_next = bvfm_pkg::ST_SCALE;
            end
            bvfm_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = bvfm_pkg::ST_FILTER;
            end
            bvfm_pkg::ST_FILTER:
            begin
                cmd.filter = 1'b1;
                state_next = bvfm_pkg::ST_ACCUM;
            end
            bvfm_pkg::ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = bvfm_pkg::ST_DECIDE;
            end
            bvfm_pkg::ST_DECIDE:
            begin
                // take the next request while the result register loads
                if (out_free)
                begin
                    cmd.decide   = 1'b1;
                    sample_stall = 1'b0;
                    cmd.load     = sample_valid;
                    state_next   = sample_valid ? bvfm_pkg::ST_SCALE : bvfm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bvfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.decide)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bvfm_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

// File: hdl/bvfm_confirm.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor confirm counter step
// Saturating debounce count with limit capped to the counter range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvfm_confirm #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic [COUNTER_WIDTH-1:0]   count,
    input  logic                       cond,
    input  logic [bvfm_pkg::REG_W-1:0] limit,
    output logic [COUNTER_WIDTH-1:0]   count_next,
    output logic                       hit
);

    localparam int LW = (COUNTER_WIDTH > bvfm_pkg::REG_W) ? COUNTER_WIDTH : bvfm_pkg::REG_W;
    localparam logic [COUNTER_WIDTH-1:0] CMAX = {COUNTER_WIDTH{1'b1}};

    logic [LW-1:0]            limit_ext;
    logic [LW-1:0]            cmax_ext;
    logic [COUNTER_WIDTH-1:0] cap;

    assign limit_ext = LW'(limit);
    assign cmax_ext  = LW'(CMAX);
    assign cap       = (limit_ext < cmax_ext) ? COUNTER_WIDTH'(limit) : CMAX;

    always_comb
    begin
        if (!cond)
            count_next = '0;
        else if (count < cap)
            count_next = count + COUNTER_WIDTH'(1);
        else
            count_next = count;
        hit = cond && (count_next >= cap);
    end

endmodule

// File: hdl/bvfm_datapath.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor datapath
// Scale multiply, low-pass filter multiply and clamp, confirm counters, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvfm_datapath #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bvfm_pkg::cmd_t                cmd,
    input  bvfm_pkg::cfg_t                cfg,
    input  logic [15:0]                   raw_sample,
    input  logic                          monitoring_active,
    input  logic                          fault_present,
    output logic [bvfm_pkg::VOLT_W-1:0]   bus_voltage,
    output logic [bvfm_pkg::VOLT_W-1:0]   filtered_voltage,
    output logic [bvfm_pkg::CODE_W-1:0]   fault_code
);

    localparam int VW = bvfm_pkg::VOLT_W;
    localparam int AW = bvfm_pkg::ACC_W;
    localparam int CW = COUNTER_WIDTH;
    localparam logic [15:0] RAW_MASK = (SAMPLE_WIDTH >= 16) ? 16'hFFFF :
                                       16'((32'd1 << SAMPLE_WIDTH) - 32'd1);
    localparam logic [AW-1:0] ACC_MAX = {AW{1'b1}};

    // input request
    logic [15:0] raw_reg;
    logic        active_reg;
    logic        present_reg;

    // scale and filter
    logic [31:0]        prod_reg;
    logic [VW-1:0]      bus_reg;
    logic [VW-1:0]      bus_next;
    logic [32:0]        bus_round;
    logic signed [AW:0] diff;
    logic signed [41:0] step_reg;
    logic signed [41:0] step_next;
    logic signed [42:0] step_biased;
    logic signed [26:0] step_shift;
    logic signed [26:0] acc_sum;
    logic [AW-1:0]      acc_reg;
    logic [AW-1:0]      acc_next;

    // decide
    logic [AW:0]        filt_round;
    logic [VW-1:0]      filt;
    logic [CW-1:0]      hard_reg, over_reg, under_reg;
    logic [CW-1:0]      hard_next, over_next, under_next;
    logic [CW-1:0]      hard_step, over_step, under_step;
    logic               hard_hit, over_hit, under_hit;
    logic [bvfm_pkg::CODE_W-1:0] code;

    // result register
    logic [VW-1:0]      bus_out_reg;
    logic [VW-1:0]      filt_out_reg;
    logic [bvfm_pkg::CODE_W-1:0] code_out_reg;

    assign bus_round = 33'(prod_reg) + 33'd128;
    assign bus_next  = (|bus_round[32:24]) ? {VW{1'b1}} : bus_round[23:8];
    assign diff      = $signed({1'b0, bus_next, 8'b0}) - $signed({1'b0, acc_reg});
    assign step_next = 42'(diff * $signed({1'b0, cfg.filter_alpha}));

    assign step_biased = 43'(step_reg) + 43'sd32768;
    assign step_shift  = 27'(step_biased >>> 16);
    assign acc_sum     = $signed({3'b0, acc_reg}) + step_shift;

    always_comb
    begin
        if (acc_sum < 0)
            acc_next = '0;
        else if (acc_sum > $signed({3'b0, ACC_MAX}))
            acc_next = ACC_MAX;
        else
            acc_next = acc_sum[AW-1:0];
    end

    assign filt_round = (AW + 1)'(acc_reg) + (AW + 1)'(128);
    assign filt       = filt_round[AW] ? {VW{1'b1}} : filt_round[AW-1:8];

    bvfm_confirm #(.COUNTER_WIDTH(CW)) u_hard (
        .count      (hard_reg),
        .cond       (bus_reg >= cfg.hard_ov_level),
        .limit      (cfg.hard_confirm),
        .count_next (hard_step),
        .hit        (hard_hit)
    );

    bvfm_confirm #(.COUNTER_WIDTH(CW)) u_over (
        .count      (over_reg),
        .cond       (filt >= cfg.ov_level),
        .limit      (cfg.ov_confirm),
        .count_next (over_step),
        .hit        (over_hit)
    );

    bvfm_confirm #(.COUNTER_WIDTH(CW)) u_under (
        .count      (under_reg),
        .cond       (filt <= cfg.uv_level),
        .limit      (cfg.uv_confirm),
        .count_next (under_step),
        .hit        (under_hit)
    );

    always_comb
    begin
        hard_next  = hard_reg;
        over_next  = over_reg;
        under_next = under_reg;
        code       = bvfm_pkg::FAULT_NONE;
        if (!active_reg)
        begin
            hard_next  = '0;
            over_next  = '0;
            under_next = '0;
        end
        else if (!present_reg)
        begin
            hard_next = hard_step;
            if (hard_hit)
            begin
                code = bvfm_pkg::FAULT_OVER;
            end
            else
            begin
                over_next  = over_step;
                under_next = under_step;
                if (over_hit)
                    code = bvfm_pkg::FAULT_OVER;
                else if (under_hit)
                    code = bvfm_pkg::FAULT_UNDER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg     <= raw_sample & RAW_MASK;
            active_reg  <= monitoring_active;
            present_reg <= fault_present;
        end
        if (cmd.scale)
            prod_reg <= 32'(raw_reg) * 32'(cfg.volts_per_count);
        if (cmd.filter)
        begin
            bus_reg  <= bus_next;
            step_reg <= step_next;
        end
        if (cmd.decide)
        begin
            bus_out_reg  <= bus_reg;
            filt_out_reg <= filt;
            code_out_reg <= code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            hard_reg  <= '0;
            over_reg  <= '0;
            under_reg <= '0;
        end
        else
        begin
            if (cmd.accum)
                acc_reg <= acc_next;
            if (cmd.decide)
            begin
                hard_reg  <= hard_next;
                over_reg  <= over_next;
                under_reg <= under_next;
            end
        end
    end

    assign bus_voltage      = bus_out_reg;
    assign filtered_voltage = filt_out_reg;
    assign fault_code       = code_out_reg;

endmodule

// File: hdl/bus_voltage_fault_monitor.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor
// Scales a raw bus sample to volts, low-pass filters it and debounces hard
// overvoltage, overvoltage and undervoltage conditions into a fault code.
// ----------------------------------------------------------------------------
// A sample is accepted, while results are drained, once per pass of the four-step
// sequencer: scale multiply, filter multiply, accumulate and clamp, then the
// confirm counters and result load, after which result valid is registered;
// the next sample is accepted during that last step. A stalled result holds
// the decide step until the result register frees. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module bus_voltage_fault_monitor #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic [15:0]                    raw_sample,
    input  logic                           monitoring_active,
    input  logic                           fault_present,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [bvfm_pkg::VOLT_W-1:0]    bus_voltage,
    output logic [bvfm_pkg::VOLT_W-1:0]    filtered_voltage,
    output logic [bvfm_pkg::CODE_W-1:0]    fault_code,
    input  logic                           cfg_write_enable,
    input  logic [bvfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bvfm_pkg::REG_W-1:0]     cfg_data
);

    bvfm_pkg::cfg_t cfg;
    bvfm_pkg::cmd_t cmd;

    bvfm_cfg_regs u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cfg              (cfg)
    );

    bvfm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    bvfm_datapath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .raw_sample        (raw_sample),
        .monitoring_active (monitoring_active),
        .fault_present     (fault_present),
        .bus_voltage       (bus_voltage),
        .filtered_voltage  (filtered_voltage),
        .fault_code        (fault_code)
    );

endmodule

// File: hdl/bvfm_checker.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor checker
// Port-level checks on sequencing and result stability, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bus_voltage_fault_monitor_assert.svh"

module bvfm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           sample_valid,
    input logic                           sample_stall,
    input logic                           result_valid,
    input logic                           result_stall,
    input logic [bvfm_pkg::VOLT_W-1:0]    bus_voltage,
    input logic [bvfm_pkg::VOLT_W-1:0]    filtered_voltage,
    input logic [bvfm_pkg::CODE_W-1:0]    fault_code
);

    logic sample_take;
    logic sample_take_d4;
    logic out_held;
    logic [2*bvfm_pkg::VOLT_W+bvfm_pkg::CODE_W-1:0] result_word;

    assign sample_take = sample_valid && !sample_stall;
    assign out_held    = result_valid && result_stall;
    assign result_word = {bus_voltage, filtered_voltage, fault_code};

    // accepted request, delayed through the take_pipe shift register
    logic [3:0] take_pipe_reg;
    logic [3:0] take_pipe_next;

    assign take_pipe_next = {take_pipe_reg[2:0], sample_take};
    assign sample_take_d4 = take_pipe_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            take_pipe_reg <= '0;
        else
            take_pipe_reg <= take_pipe_next;
    end

    `BVFM_ASSERT_NEXT(a_no_back_to_back, sample_take, sample_stall)

    `BVFM_ASSERT_NOW(a_code_legal, result_valid, fault_code <= bvfm_pkg::FAULT_UNDER)

    `BVFM_ASSERT_NEXT(a_result_follows, sample_take_d4, result_valid)

    `BVFM_ASSERT_NEXT(a_result_hold, out_held, result_valid && $stable(result_word))

endmodule

bind bus_voltage_fault_monitor bvfm_checker u_bvfm_checker (.*);

// File: bench/bus_voltage_fault_monitor_test.sv
// ----------------------------------------------------------------------------
// Bus voltage fault monitor testbench
// Streams bus samples through the monitor under random input gaps and result
// stalls, predicts scaled and filtered voltage and the debounced fault code
// for every accepted request, and checks each result field by field. Runs a
// short directed phase, extreme register settings, then random phases built
// from held voltage runs near the trip levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_voltage_fault_monitor_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 37;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 70;

    typedef struct packed {
        logic [15:0] raw;
        logic        active;
        logic        present;
    } sample_t;

    typedef struct packed {
        logic [bvfm_pkg::VOLT_W-1:0] bus;
        logic [bvfm_pkg::VOLT_W-1:0] filt;
        logic [bvfm_pkg::CODE_W-1:0] code;
    } reading_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           sample_valid = 1'b0;
    logic                           sample_stall;
    logic [15:0]                    raw_sample = '0;
    logic                           monitoring_active = 1'b0;
    logic                           fault_present = 1'b0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [bvfm_pkg::VOLT_W-1:0]    bus_voltage;
    logic [bvfm_pkg::VOLT_W-1:0]    filtered_voltage;
    logic [bvfm_pkg::CODE_W-1:0]    fault_code;
    logic                           cfg_write_enable = 1'b0;
    logic [bvfm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bvfm_pkg::REG_W-1:0]     cfg_data = '0;

    bvfm_pkg::cfg_t settings;
    logic [23:0]    filter_acc;
    logic [15:0]    hard_cnt;
    logic [15:0]    over_cnt;
    logic [15:0]    under_cnt;

    sample_t  sample_backlog[$];
    reading_t expected_readings[$];
    int       samples_queued = 0;
    int       readings_seen = 0;
    int       mismatches = 0;
    int       cycle_count = 0;
    wire      calm = (readings_seen >= 220) && (readings_seen < 320);

    bus_voltage_fault_monitor dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .raw_sample        (raw_sample),
        .monitoring_active (monitoring_active),
        .fault_present     (fault_present),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .bus_voltage       (bus_voltage),
        .filtered_voltage  (filtered_voltage),
        .fault_code        (fault_code),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic confirm_tick(inout logic [15:0] count, input logic cond,
                                          input logic [15:0] limit);
        if (!cond)
        begin
            count = '0;
            return 1'b0;
        end
        if (count < limit)
            count = count + 16'd1;
        return count >= limit;
    endfunction

    function automatic reading_t predict_reading(input sample_t s);
        reading_t r;
        longint   scaled;
        longint   step;
        longint   next_acc;
        longint   smooth;
        logic     ov_hit;
        logic     uv_hit;
        scaled = (longint'(s.raw) * longint'(settings.volts_per_count) + 128) >>> 8;
        if (scaled > 65535)
            scaled = 65535;
        step = ((scaled <<< 8) - longint'(filter_acc)) * longint'(settings.filter_alpha)
               + 32768;
        next_acc = longint'(filter_acc) + (step >>> 16);
        if (next_acc < 0)
            next_acc = 0;
        if (next_acc > 64'hFF_FFFF)
            next_acc = 64'hFF_FFFF;
        filter_acc = next_acc[23:0];
        smooth = (next_acc + 128) >>> 8;
        if (smooth > 65535)
            smooth = 65535;
        r.bus  = scaled[15:0];
        r.filt = smooth[15:0];
        r.code = bvfm_pkg::FAULT_NONE;
        if (!s.active)
        begin
            hard_cnt  = '0;
            over_cnt  = '0;
            under_cnt = '0;
        end
        else if (!s.present)
        begin
            if (confirm_tick(hard_cnt, r.bus >= settings.hard_ov_level, settings.hard_confirm))
                r.code = bvfm_pkg::FAULT_OVER;
            else
            begin
                ov_hit = confirm_tick(over_cnt, r.filt >= settings.ov_level, settings.ov_confirm);
                uv_hit = confirm_tick(under_cnt, r.filt <= settings.uv_level,
                                      settings.uv_confirm);
                if (ov_hit)
                    r.code = bvfm_pkg::FAULT_OVER;
                else if (uv_hit)
                    r.code = bvfm_pkg::FAULT_UNDER;
            end
        end
        return r;
    endfunction

    // Sample driver: predict on accept, hold a stalled request, idle at random.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_t nxt;
        if (!rst_n)
        begin
            sample_valid      <= 1'b0;
            raw_sample        <= '0;
            monitoring_active <= 1'b0;
            fault_present     <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                expected_readings.push_back(
                    predict_reading({raw_sample, monitoring_active, fault_present}));
            if (!sample_valid || !sample_stall)
            begin
                if (sample_backlog.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    nxt = sample_backlog.pop_front();
                    sample_valid      <= 1'b1;
                    raw_sample        <= nxt.raw;
                    monitoring_active <= nxt.active;
                    fault_present     <= nxt.present;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare against the oldest prediction, stall at random.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        reading_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result bus %0d filt %0d code %0d", $time,
                             bus_voltage, filtered_voltage, fault_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (bus_voltage !== want.bus)
                    begin
                        $display("%0t: bus_voltage expected %0d actual %0d", $time,
                                 want.bus, bus_voltage);
                        mismatches++;
                    end
                    if (filtered_voltage !== want.filt)
                    begin
                        $display("%0t: filtered_voltage expected %0d actual %0d", $time,
                                 want.filt, filtered_voltage);
                        mismatches++;
                    end
                    if (fault_code !== want.code)
                    begin
                        $display("%0t: fault_code expected %0d actual %0d", $time,
                                 want.code, fault_code);
                        mismatches++;
                    end
                end
                readings_seen++;
            end
            result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    task automatic queue_sample(input logic [15:0] raw, input logic active,
                                input logic present);
        sample_backlog.push_back('{raw: raw, active: active, present: present});
        samples_queued++;
    endtask

    task automatic load_settings(input bvfm_pkg::cfg_t c);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= bvfm_pkg::CFG_VOLTS_PER_COUNT;
        cfg_data         <= c.volts_per_count;
        @(posedge clk);
        cfg_index        <= bvfm_pkg::CFG_FILTER_ALPHA;
        cfg_data         <= c.filter_alpha;
        @(posedge clk);
        cfg_index        <= bvfm_pkg::CFG_HARD_OV_LEVEL;
        cfg_data         <= c.hard_ov_level;
        @(posedge clk);
        cfg_index        <= bvfm_pkg::CFG_OV_LEVEL;
        cfg_data         <= c.ov_level;
        @(posedge clk);
        cfg_index        <= bvfm_pkg::CFG_UV_LEVEL;
        cfg_data         <= c.uv_level;
        @(posedge clk);
        cfg_index        <= bvfm_pkg::CFG_HARD_CONFIRM;
        cfg_data         <= c.hard_confirm;
        @(posedge clk);
        cfg_index        <= bvfm_pkg::CFG_OV_CONFIRM;
        cfg_data         <= c.ov_confirm;
        @(posedge clk);
        cfg_index        <= bvfm_pkg::CFG_UV_CONFIRM;
        cfg_data         <= c.uv_confirm;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        settings = c;
    endtask

    task automatic drain;
        wait (readings_seen == samples_queued);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic bvfm_pkg::cfg_t random_settings();
        bvfm_pkg::cfg_t c;
        c.volts_per_count = pick_value(64, 1024);
        c.filter_alpha    = pick_value(2000, 40000);
        c.hard_ov_level   = pick_value(20000, 60000);
        c.ov_level        = pick_value(8000, 30000);
        c.uv_level        = pick_value(500, 8000);
        if ($urandom_range(0, 99) < 15)
            c.uv_level = c.ov_level | 16'h0400;
        c.hard_confirm    = pick_value(0, 6);
        c.ov_confirm      = pick_value(0, 8);
        c.uv_confirm      = pick_value(0, 8);
        return c;
    endfunction

    function automatic logic [15:0] raw_near(input logic [15:0] level);
        int v;
        if (settings.volts_per_count == 0)
            return 16'($urandom);
        v = (int'(level) * 256) / int'(settings.volts_per_count);
        v = v + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Held voltage runs near the trip levels, with some noise in between.
    task automatic queue_runs(input int count);
        int          left;
        int          run_len;
        logic [15:0] level;
        logic        active;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                queue_sample(16'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                left--;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: level = settings.uv_level;
                    1: level = settings.ov_level;
                    2: level = settings.hard_ov_level;
                    3: level = (settings.ov_level >> 1) + (settings.uv_level >> 1);
                    4: level = '0;
                    default: level = 16'($urandom);
                endcase
                active  = ($urandom_range(0, 9) != 0);
                run_len = $urandom_range(1, 12);
                while (run_len > 0 && left > 0)
                begin
                    queue_sample(raw_near(level), active, $urandom_range(0, 9) == 0);
                    run_len--;
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("bus_voltage_fault_monitor: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        settings = '{volts_per_count: bvfm_pkg::RST_VOLTS_PER_COUNT,
                     filter_alpha:    bvfm_pkg::RST_FILTER_ALPHA,
                     hard_ov_level:   bvfm_pkg::RST_HARD_OV_LEVEL,
                     ov_level:        bvfm_pkg::RST_OV_LEVEL,
                     uv_level:        bvfm_pkg::RST_UV_LEVEL,
                     hard_confirm:    bvfm_pkg::RST_HARD_CONFIRM,
                     ov_confirm:      bvfm_pkg::RST_OV_CONFIRM,
                     uv_confirm:      bvfm_pkg::RST_UV_CONFIRM};
        filter_acc = '0;
        hard_cnt   = '0;
        over_cnt   = '0;
        under_cnt  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: hard trip confirms, holds at cap, fault present, inactive
        queue_sample(16'h0000, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1'b1, 1'b1);
        queue_sample(16'hFFFF, 1'b0, 1'b0);
        queue_sample(16'h0000, 1'b1, 1'b1);
        drain();

        // both filtered trips in one tick, zero hard limit, saturated bus
        load_settings('{volts_per_count: 16'hFFFF, filter_alpha: 16'hFFFF,
                        hard_ov_level: 16'hFFFF, ov_level: 16'h0100, uv_level: 16'h0200,
                        hard_confirm: 16'd0, ov_confirm: 16'd1, uv_confirm: 16'd3});
        queue_sample(16'h0001, 1'b1, 1'b0);
        queue_sample(16'h0001, 1'b1, 1'b0);
        queue_sample(16'h0001, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'h0000, 1'b1, 1'b0);
        drain();

        load_settings('0);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'h5555, 1'b1, 1'b0);
        queue_sample(16'hAAAA, 1'b0, 1'b1);
        drain();

        load_settings('1);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'h0000, 1'b1, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_settings(random_settings());
            queue_runs(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0 && expected_readings.size() == 0)
            $display("bus_voltage_fault_monitor: match");
        else
            $display("bus_voltage_fault_monitor: mismatch");
        $finish;
    end

endmodule
